>>> hw/rtl/ccbs_pkg.sv
package ccbs_pkg;

    // Field widths of the request and result channels.
    localparam int W_REQ_TYPE    = 1;
    localparam int W_CHANNEL     = 6;
    localparam int W_VALUE       = 8;
    localparam int W_BLOCK_START = 6;
    localparam int W_BLOCK_LEN   = 5;

    // Default sizing of the scanner.
    localparam int CHANNELS_DEF  = 64;
    localparam int MAX_BLOCK_DEF = 16;
    localparam int MIN_GAP_DEF   = 3;

    // A scan never reports more blocks than this.
    localparam int RESULT_CAP = 24;

    // Request type codes.
    localparam logic [W_REQ_TYPE-1:0] REQ_WRITE = 1'b0;
    localparam logic [W_REQ_TYPE-1:0] REQ_SCAN  = 1'b1;

    // Write enables of the two value stores.
    typedef struct packed {
        logic cur;
        logic snt;
    } t_mem_wr;

    // One result as it leaves the block.
    typedef struct packed {
        logic [W_BLOCK_START-1:0] block_start;
        logic [W_BLOCK_LEN-1:0]   block_len;
        logic                     last;
    } t_res;

endpackage

>>> hw/rtl/ccbs_if.sv
interface ccbs_in_if;
    import ccbs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [W_REQ_TYPE-1:0] req_type;
    logic [W_CHANNEL-1:0]  channel;
    logic [W_VALUE-1:0]    value;

    modport source (output valid, req_type, channel, value, input ready);
    modport sink (input valid, req_type, channel, value, output ready);
endinterface

interface ccbs_out_if;
    import ccbs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [W_BLOCK_START-1:0] block_start;
    logic [W_BLOCK_LEN-1:0]   block_len;
    logic                     last;

    modport source (output valid, block_start, block_len, last, input ready);
    modport sink (input valid, block_start, block_len, last, output ready);
endinterface

>>> hw/rtl/ccbs_mem.sv
module ccbs_mem #(
    parameter int CHANNELS = ccbs_pkg::CHANNELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ccbs_pkg::t_mem_wr                i_wr,
    input  logic [$clog2(CHANNELS)-1:0]      i_cur_addr,
    input  logic [ccbs_pkg::W_VALUE-1:0]     i_cur_data,
    input  logic [$clog2(CHANNELS)-1:0]      i_snt_addr,
    input  logic [ccbs_pkg::W_VALUE-1:0]     i_snt_data,
    input  logic [$clog2(CHANNELS)-1:0]      i_rd_addr,
    output logic [ccbs_pkg::W_VALUE-1:0]     o_cur,
    output logic [ccbs_pkg::W_VALUE-1:0]     o_snt
);
    import ccbs_pkg::*;

    logic [W_VALUE-1:0] r_cur_mem [CHANNELS];
    logic [W_VALUE-1:0] r_snt_mem [CHANNELS];
    logic               r_cur_vld [CHANNELS];
    logic               r_snt_vld [CHANNELS];
    logic [W_VALUE-1:0] r_cur_q;
    logic [W_VALUE-1:0] r_snt_q;
    logic               r_cur_qv;
    logic               r_snt_qv;

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < CHANNELS; e++) begin
                r_cur_vld[e] <= 1'b0;
                r_snt_vld[e] <= 1'b0;
            end
        end else begin
            if (i_wr.cur) begin
                r_cur_vld[i_cur_addr] <= 1'b1;
            end
            if (i_wr.snt) begin
                r_snt_vld[i_snt_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.cur) begin
            r_cur_mem[i_cur_addr] <= i_cur_data;
        end
        if (i_wr.snt) begin
            r_snt_mem[i_snt_addr] <= i_snt_data;
        end
        r_cur_q  <= r_cur_mem[i_rd_addr];
        r_snt_q  <= r_snt_mem[i_rd_addr];
        r_cur_qv <= r_cur_vld[i_rd_addr];
        r_snt_qv <= r_snt_vld[i_rd_addr];
    end

    assign o_cur = r_cur_qv ? r_cur_q : '0;
    assign o_snt = r_snt_qv ? r_snt_q : '0;

endmodule

>>> hw/rtl/changed_channel_block_scanner.sv
// Changed-channel block scanner.
// Requests arrive on i_req (valid/ready). A write request stores one channel
// value and produces no result; writes to channels at or above CHANNELS are
// dropped. A scan request walks the current and last-sent stores, one channel
// per cycle while the walk is not stalled, starting at the round-robin
// pointer, and reports each run of changed channels on o_res as a start and a
// length. Every reported block is copied into the sent store as it is walked.
// The final result of a scan carries last; when nothing differs, a single
// result with zero length and last is given.
// During a scan the walk reads one channel per cycle from the two value
// memories unless stalled, and a block cut at MAX_BLOCK on a changed channel
// makes the walk look at that channel again. No new request is taken during a
// scan. Results pass through a holding slot and an output register, so a
// stalled receiver only halts the walk when both are full.
// After reset both stores read as zero and the pointer is zero; reset is
// synchronous and active low.
module changed_channel_block_scanner #(
    parameter int CHANNELS  = ccbs_pkg::CHANNELS_DEF,
    parameter int MAX_BLOCK = ccbs_pkg::MAX_BLOCK_DEF,
    parameter int MIN_GAP   = ccbs_pkg::MIN_GAP_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    ccbs_in_if.sink    i_req,
    ccbs_out_if.source o_res
);
    import ccbs_pkg::*;

    localparam int AW = $clog2(CHANNELS);
    localparam int LW = $clog2(MAX_BLOCK + 1);
    localparam int KW = $clog2(MAX_BLOCK + MIN_GAP);
    localparam int QW = KW + 1;
    localparam int GW = $clog2(MIN_GAP + 1);
    localparam int CW = $clog2(CHANNELS) + 3;
    localparam int NW = $clog2(RESULT_CAP + 1);

    localparam logic [AW-1:0] LAST_CH = AW'(CHANNELS - 1);
    localparam logic [AW:0]   CH_P    = (AW + 1)'(CHANNELS);
    localparam logic [CW-1:0] CH_C    = CW'(CHANNELS);
    localparam logic [QW-1:0] MAX_Q   = QW'(MAX_BLOCK);
    localparam logic [LW-1:0] MAX_L   = LW'(MAX_BLOCK);
    localparam logic [GW-1:0] GAP_G   = GW'(MIN_GAP);
    localparam logic [NW-1:0] CAP_N   = NW'(RESULT_CAP);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [AW-1:0]   r_i, n_i;
    logic            r_blk, n_blk;
    logic            r_wrap, n_wrap;
    logic [AW-1:0]   r_s, n_s;
    logic [KW-1:0]   r_k, n_k;
    logic [GW-1:0]   r_run, n_run;
    logic [CW-1:0]   r_chk, n_chk;
    logic [NW-1:0]   r_n, n_n;
    logic            r_pend_vld, n_pend_vld;
    t_res            r_pend, n_pend;
    logic            r_out_vld, n_out_vld;
    t_res            r_out, n_out;

    t_mem_wr         wr;
    logic [W_VALUE-1:0] w_cur;
    logic [W_VALUE-1:0] w_snt;
    logic            ch_ok;

    logic            diff;
    logic            last_ch;
    logic            start_now;
    logic            end_d;
    logic            end_gap;
    logic            end_arr;
    logic            blk_end;
    logic            brk;
    logic            out_free;
    logic            stall;
    logic            is_final;
    logic [AW-1:0]   i_inc;
    logic [AW-1:0]   s_e;
    logic [AW-1:0]   ptr_new;
    logic [AW:0]     ptr_sum;
    logic [KW-1:0]   k_e;
    logic [GW-1:0]   run_e;
    logic [GW-1:0]   run_new;
    logic [QW-1:0]   kp1;
    logic [QW-1:0]   q;
    logic [LW-1:0]   len;
    logic [CW-1:0]   chk_base;
    logic [CW-1:0]   chk_end;
    logic [NW-1:0]   n_inc;

    // Value stores; the read address is the channel the walk looks at next.
    ccbs_mem #(
        .CHANNELS(CHANNELS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_cur_addr(AW'(i_req.channel)),
        .i_cur_data(i_req.value),
        .i_snt_addr(r_i),
        .i_snt_data(w_cur),
        .i_rd_addr (n_i),
        .o_cur     (w_cur),
        .o_snt     (w_snt)
    );

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_res.valid       = r_out_vld;
    assign o_res.block_start = r_out.block_start;
    assign o_res.block_len   = r_out.block_len;
    assign o_res.last        = r_out.last;

    assign ch_ok = int'(i_req.channel) < CHANNELS;

    // Per-channel evaluation of the walk. In search mode a changed channel
    // opens a block at offset zero, so the same end tests cover both modes.
    always_comb begin
        diff      = (w_cur != w_snt);
        last_ch   = (r_i == LAST_CH);
        i_inc     = last_ch ? '0 : r_i + 1'b1;
        start_now = !r_blk && diff;
        s_e       = r_blk ? r_s : r_i;
        k_e       = r_blk ? r_k : '0;
        run_e     = r_blk ? r_run : '0;
        run_new   = diff ? '0 : run_e + 1'b1;
        kp1       = QW'(k_e) + 1'b1;
        q         = kp1 - QW'(run_new);

        // A changed channel past the cap closes the block and is looked at
        // again as the start of the next one.
        end_d   = r_blk && diff && (QW'(k_e) >= MAX_Q);
        // A full gap, or an unchanged run that can only start past the cap.
        end_gap = r_blk && !diff && ((run_new == GAP_G) || (q >= MAX_Q));
        // The block reaches the end of the array.
        end_arr = (r_blk || diff) && last_ch && !end_d && !end_gap;
        blk_end = end_d || end_gap || end_arr;

        priority if (end_d) begin
            len = MAX_L;
        end else if (end_gap) begin
            len = (q >= MAX_Q) ? MAX_L : LW'(q);
        end else begin
            len = (kp1 >= MAX_Q) ? MAX_L : LW'(kp1);
        end

        // The distance skipped over the wrap counts toward the scan budget.
        chk_base = (start_now && r_wrap) ? r_chk + CW'(r_i) : r_chk;
        chk_end  = chk_base + CW'(len);
        ptr_sum  = (AW + 1)'(s_e) + (AW + 1)'(len);
        ptr_new  = (ptr_sum == CH_P) ? '0 : ptr_sum[AW-1:0];
        n_inc    = r_n + 1'b1;
        is_final = (chk_end >= CH_C) || (n_inc == CAP_N);

        // Search gives up at the array end when it started at channel zero,
        // or after the wrap once it is back at the pointer.
        brk = last_ch ? (r_ptr == '0) : (r_wrap && (i_inc == r_ptr));

        out_free = !r_out_vld || o_res.ready;
        stall    = blk_end && r_pend_vld && !out_free;
    end

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_i        = r_i;
        n_blk      = r_blk;
        n_wrap     = r_wrap;
        n_s        = r_s;
        n_k        = r_k;
        n_run      = r_run;
        n_chk      = r_chk;
        n_n        = r_n;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_out_vld  = r_out_vld && !o_res.ready;
        n_out      = r_out;
        wr         = '0;

        unique case (r_state)
            ST_IDLE: begin
                // Keep the read port on the pointer so a scan starts with data.
                n_i = r_ptr;
                if (i_req.valid) begin
                    unique case (i_req.req_type)
                        REQ_WRITE: begin
                            wr.cur = ch_ok;
                        end
                        REQ_SCAN: begin
                            n_state = ST_SCAN;
                            n_blk   = 1'b0;
                            n_wrap  = 1'b0;
                            n_chk   = '0;
                            n_n     = '0;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (blk_end) begin
                    if (!stall) begin
                        wr.snt     = diff && !end_d;
                        n_ptr      = ptr_new;
                        n_n        = n_inc;
                        n_chk      = chk_end;
                        n_blk      = 1'b0;
                        n_wrap     = 1'b0;
                        if (r_pend_vld) begin
                            n_out     = r_pend;
                            n_out_vld = 1'b1;
                        end
                        n_pend.block_start = W_BLOCK_START'(s_e);
                        n_pend.block_len   = W_BLOCK_LEN'(len);
                        n_pend.last        = is_final;
                        n_pend_vld         = 1'b1;
                        if (is_final) begin
                            n_state = ST_FLUSH;
                        end else if (end_d) begin
                            n_i = r_i;
                        end else if (last_ch) begin
                            // The rest of the array is unchanged: search from
                            // channel zero, as a wrap unless the block ended
                            // exactly at the array end.
                            n_i = '0;
                            if (ptr_new != '0) begin
                                n_wrap = 1'b1;
                                n_chk  = chk_end + CH_C - CW'(ptr_new);
                            end
                        end else begin
                            n_i = i_inc;
                        end
                    end
                end else if (r_blk || diff) begin
                    wr.snt = diff;
                    n_blk  = 1'b1;
                    n_s    = s_e;
                    n_k    = k_e + 1'b1;
                    n_run  = run_new;
                    n_chk  = chk_base;
                    n_wrap = 1'b0;
                    n_i    = i_inc;
                end else if (brk) begin
                    if (r_pend_vld) begin
                        n_pend.last = 1'b1;
                    end else begin
                        n_pend.block_start = '0;
                        n_pend.block_len   = '0;
                        n_pend.last        = 1'b1;
                    end
                    n_pend_vld = 1'b1;
                    n_state    = ST_FLUSH;
                end else begin
                    n_i = i_inc;
                    if (last_ch) begin
                        n_wrap = 1'b1;
                        n_chk  = r_chk + CH_C - CW'(r_ptr);
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out      = r_pend;
                    n_out_vld  = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ptr      <= '0;
            r_i        <= '0;
            r_blk      <= 1'b0;
            r_wrap     <= 1'b0;
            r_chk      <= '0;
            r_n        <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ptr      <= n_ptr;
            r_i        <= n_i;
            r_blk      <= n_blk;
            r_wrap     <= n_wrap;
            r_chk      <= n_chk;
            r_n        <= n_n;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s    <= n_s;
        r_k    <= n_k;
        r_run  <= n_run;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_ptr) < CHANNELS)
        else $error("scan pointer beyond the channel count");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_vld)
        else $error("result left in holding slot after a scan");

    a_snt_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.snt |-> (r_state == ST_SCAN) && !stall)
        else $error("sent store written outside an active scan step");

    a_result_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CAP_N)
        else $error("result count beyond the cap");
`endif

endmodule
